[rtl/lsts_pkg.sv]
// Package for the LED slide transition sequencer.
// Holds the table entry layout, code constants and the controller/datapath interface.
// No dependencies.
package lsts_pkg;

  localparam int MAX_ITEMS = 8;
  localparam int TIME_BITS = 16;
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = 4;
  localparam int DIST_W = 8;
  localparam int DIV_CNT_W = $clog2(TIME_BITS);

  localparam logic [2:0] TR_APPEAR = 3'd0;
  localparam logic [2:0] TR_LEFT = 3'd1;
  localparam logic [2:0] TR_RIGHT = 3'd2;
  localparam logic [2:0] TR_UP = 3'd3;
  localparam logic [2:0] TR_DOWN = 3'd4;

  localparam logic [2:0] PAD_NONE = 3'd0;
  localparam logic [2:0] PAD_LEFT = 3'd1;
  localparam logic [2:0] PAD_RIGHT = 3'd2;
  localparam logic [2:0] PAD_TOP = 3'd3;
  localparam logic [2:0] PAD_BOTTOM = 3'd4;

  typedef struct packed {
    logic [2:0] transition;
    logic [TIME_BITS-1:0] show_ms;
    logic [TIME_BITS-1:0] slide_ms;
    logic [3:0] pad;
    logic [6:0] columns;
    logic [6:0] rows;
  } entry_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_APPEAR,
    OP_SLIDE,
    OP_HOLD,
    OP_STEP
  } op_t;

  typedef struct packed {
    logic wr_entry;
    logic rd_second;
    logic rd_use_inc;
    logic latch_cur;
    logic exec;
    op_t op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] cur_tr;
    logic step_done;
    logic div_done;
  } sts_t;

endpackage

[rtl/lsts_div.sv]
// Restoring divider for the slide interval, one quotient bit per cycle.
// Depends on lsts_pkg.
module lsts_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [lsts_pkg::TIME_BITS-1:0] dividend,
  input  logic [lsts_pkg::DIST_W-1:0]    divisor,
  output logic                           done,
  output logic [lsts_pkg::TIME_BITS-1:0] quotient
);
  import lsts_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TIME_BITS-1:0] quo_r;
  logic [DIST_W-1:0]    rem_r;
  logic [DIST_W-1:0]    dvs_r;
  logic [DIST_W:0]      trial;
  logic                 ge;
  logic [DIST_W:0]      diff;

  assign trial = {rem_r, quo_r[TIME_BITS-1]};
  assign ge = trial >= {1'b0, dvs_r};
  assign diff = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(TIME_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[TIME_BITS-2:0], ge};
      rem_r <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

[rtl/lsts_dp.sv]
// Datapath of the sequencer: item table, item state, origins, view mask and result register.
// Depends on lsts_pkg and lsts_div.
module lsts_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsts_pkg::cmd_t                 cmd,
  output lsts_pkg::sts_t                 sts,
  input  logic                           cfg_wr_en,
  input  logic [3:0]                     cfg_wr_data,
  input  logic [2:0]                     in_entry_index,
  input  logic [2:0]                     in_entry_transition,
  input  logic [15:0]                    in_entry_show_ms,
  input  logic [15:0]                    in_entry_slide_ms,
  input  logic [3:0]                     in_entry_pad,
  input  logic [6:0]                     in_entry_columns,
  input  logic [6:0]                     in_entry_rows,
  output logic [2:0]                     out_cur_index,
  output logic [2:0]                     out_next_index,
  output logic signed [7:0]              out_cur_origin_x,
  output logic signed [7:0]              out_cur_origin_y,
  output logic signed [7:0]              out_next_origin_x,
  output logic signed [7:0]              out_next_origin_y,
  output logic [15:0]                    out_interval_ms,
  output logic [7:0]                     out_visible_mask,
  output logic [2:0]                     out_pad_side,
  output logic [3:0]                     out_pad_value,
  output logic                           out_clear_pads,
  output logic                           out_redraw
);
  import lsts_pkg::*;

  entry_t mem [MAX_ITEMS];
  entry_t rd_data_r;
  entry_t c_r;
  entry_t wr_entry;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_used;
  logic [CNT_W-1:0] cur_inc;
  logic [IDX_W-1:0] nx_idx;

  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [IDX_W-1:0]     inc_r, inc_nxt;
  logic [7:0]           cx_r, cx_nxt, cy_r, cy_nxt, ix_r, ix_nxt, iy_r, iy_nxt;
  logic [MAX_ITEMS-1:0] view_r, view_nxt;
  logic [TIME_BITS-1:0] slide_iv_r;
  logic [TIME_BITS-1:0] pend_iv_r, pend_iv_nxt;
  logic [2:0]           pend_side_r, pend_side_nxt;
  logic [3:0]           pend_pad_r, pend_pad_nxt;
  logic                 pend_clr_r, pend_clr_nxt;
  logic                 pend_redraw_r, pend_redraw_nxt;

  logic [7:0]           step_ix, step_iy, step_cx, step_cy;
  logic                 step_done;
  logic [DIST_W-1:0]    slide_dist;
  logic [DIST_W-1:0]    divisor;
  logic                 div_start;
  logic                 div_done;
  logic [TIME_BITS-1:0] quotient;

  assign wr_entry = '{transition: in_entry_transition, show_ms: in_entry_show_ms,
                      slide_ms: in_entry_slide_ms, pad: in_entry_pad,
                      columns: in_entry_columns, rows: in_entry_rows};

  always_comb begin
    if (!cmd.rd_second) begin
      rd_addr = cur_r;
    end else if (cmd.rd_use_inc) begin
      rd_addr = inc_r;
    end else begin
      rd_addr = nx_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      mem[in_entry_index[IDX_W-1:0]] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
    if (cmd.latch_cur) begin
      c_r <= rd_data_r;
    end
  end

  always_comb begin
    if (cnt_r == '0) begin
      cnt_used = CNT_W'(1);
    end else if (cnt_r > CNT_W'(MAX_ITEMS)) begin
      cnt_used = CNT_W'(MAX_ITEMS);
    end else begin
      cnt_used = cnt_r;
    end
    cur_inc = CNT_W'(cur_r) + CNT_W'(1);
    nx_idx = (cur_inc >= cnt_used) ? '0 : cur_inc[IDX_W-1:0];
  end

  always_comb begin
    step_cx = cx_r;
    step_cy = cy_r;
    step_ix = ix_r;
    step_iy = iy_r;
    step_done = 1'b0;
    case (c_r.transition)
      TR_LEFT: begin
        step_cx = cx_r - 8'd1;
        step_ix = ix_r - 8'd1;
        step_done = step_ix == 8'd0;
      end
      TR_RIGHT: begin
        step_cx = cx_r + 8'd1;
        step_ix = ix_r + 8'd1;
        step_done = step_ix == 8'd0;
      end
      TR_DOWN: begin
        step_cy = cy_r + 8'd1;
        step_iy = iy_r + 8'd1;
        step_done = step_iy == 8'd0;
      end
      TR_UP: begin
        step_cy = cy_r - 8'd1;
        step_iy = iy_r - 8'd1;
        step_done = step_iy == 8'd0;
      end
      default: begin
        step_done = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (c_r.transition)
      TR_RIGHT: slide_dist = {1'b0, rd_data_r.columns} + {4'b0, c_r.pad};
      TR_LEFT:  slide_dist = {1'b0, c_r.columns} + {4'b0, c_r.pad};
      TR_DOWN:  slide_dist = {1'b0, rd_data_r.rows} + {4'b0, c_r.pad};
      default:  slide_dist = {1'b0, c_r.rows} + {4'b0, c_r.pad};
    endcase
    divisor = (slide_dist == '0) ? DIST_W'(1) : slide_dist;
  end

  assign div_start = cmd.exec && (cmd.op == OP_SLIDE);

  always_comb begin
    cur_nxt = cur_r;
    inc_nxt = inc_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    ix_nxt = ix_r;
    iy_nxt = iy_r;
    view_nxt = view_r;
    pend_iv_nxt = pend_iv_r;
    pend_side_nxt = pend_side_r;
    pend_pad_nxt = pend_pad_r;
    pend_clr_nxt = pend_clr_r;
    pend_redraw_nxt = pend_redraw_r;
    if (cmd.exec) begin
      pend_side_nxt = PAD_NONE;
      pend_pad_nxt = '0;
      pend_clr_nxt = 1'b0;
      pend_redraw_nxt = 1'b0;
      case (cmd.op)
        OP_START: begin
          cx_nxt = '0;
          cy_nxt = '0;
          ix_nxt = '0;
          iy_nxt = '0;
          inc_nxt = cur_r;
          view_nxt[cur_r] = 1'b1;
          pend_iv_nxt = c_r.show_ms;
        end
        OP_APPEAR: begin
          cx_nxt = '0;
          cy_nxt = '0;
          ix_nxt = '0;
          iy_nxt = '0;
          cur_nxt = nx_idx;
          inc_nxt = nx_idx;
          view_nxt[cur_r] = 1'b0;
          view_nxt[nx_idx] = 1'b1;
          pend_iv_nxt = rd_data_r.show_ms;
        end
        OP_SLIDE: begin
          cx_nxt = '0;
          cy_nxt = '0;
          ix_nxt = '0;
          iy_nxt = '0;
          inc_nxt = nx_idx;
          view_nxt[nx_idx] = 1'b1;
          pend_pad_nxt = c_r.pad;
          case (c_r.transition)
            TR_RIGHT: begin
              ix_nxt = 8'd0 - slide_dist;
              pend_side_nxt = PAD_LEFT;
            end
            TR_LEFT: begin
              ix_nxt = slide_dist;
              pend_side_nxt = PAD_RIGHT;
            end
            TR_DOWN: begin
              iy_nxt = 8'd0 - slide_dist;
              pend_side_nxt = PAD_TOP;
            end
            default: begin
              iy_nxt = slide_dist;
              pend_side_nxt = PAD_BOTTOM;
            end
          endcase
        end
        OP_STEP: begin
          pend_redraw_nxt = 1'b1;
          if (step_done) begin
            pend_clr_nxt = 1'b1;
            view_nxt[cur_r] = 1'b0;
            cur_nxt = inc_r;
            cx_nxt = '0;
            cy_nxt = '0;
            ix_nxt = '0;
            iy_nxt = '0;
            pend_iv_nxt = rd_data_r.show_ms;
          end else begin
            cx_nxt = step_cx;
            cy_nxt = step_cy;
            ix_nxt = step_ix;
            iy_nxt = step_iy;
            pend_iv_nxt = slide_iv_r;
          end
        end
        default: begin
          pend_iv_nxt = c_r.show_ms;
        end
      endcase
    end else if (div_done) begin
      pend_iv_nxt = quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(1);
      cur_r <= '0;
      inc_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
      ix_r <= '0;
      iy_r <= '0;
      view_r <= '0;
      slide_iv_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
      cur_r <= cur_nxt;
      inc_r <= inc_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      ix_r <= ix_nxt;
      iy_r <= iy_nxt;
      view_r <= view_nxt;
      if (div_done) begin
        slide_iv_r <= quotient;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_iv_r <= pend_iv_nxt;
    pend_side_r <= pend_side_nxt;
    pend_pad_r <= pend_pad_nxt;
    pend_clr_r <= pend_clr_nxt;
    pend_redraw_r <= pend_redraw_nxt;
    if (cmd.load_out) begin
      out_cur_index <= cur_r;
      out_next_index <= inc_r;
      out_cur_origin_x <= cx_r;
      out_cur_origin_y <= cy_r;
      out_next_origin_x <= ix_r;
      out_next_origin_y <= iy_r;
      out_interval_ms <= pend_iv_r;
      out_visible_mask <= view_r;
      out_pad_side <= pend_side_r;
      out_pad_value <= pend_pad_r;
      out_clear_pads <= pend_clr_r;
      out_redraw <= pend_redraw_r;
    end
  end

  lsts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (c_r.slide_ms),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.cur_tr = c_r.transition;
  assign sts.step_done = step_done;
  assign sts.div_done = div_done;

endmodule

[rtl/lsts_ctrl.sv]
// Controller of the sequencer: handshakes, playlist phase and datapath command sequencing.
// Depends on lsts_pkg.
module lsts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lsts_pkg::sts_t sts,
  output lsts_pkg::cmd_t cmd
);
  import lsts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CUR,
    S_RD_NXT,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_ITEM,
    PH_SLIDE
  } ph_t;

  state_t state_r, state_nxt;
  ph_t    phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall = state_r != S_IDLE;
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.op = OP_START;
    state_nxt = state_r;
    phase_nxt = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.wr_entry = accept && in_func;
        if (accept && !in_func) begin
          state_nxt = S_RD_CUR;
        end
      end
      S_RD_CUR: begin
        state_nxt = S_RD_NXT;
      end
      S_RD_NXT: begin
        cmd.rd_second = 1'b1;
        cmd.rd_use_inc = phase_r == PH_SLIDE;
        cmd.latch_cur = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_OUT;
        case (phase_r)
          PH_ITEM: begin
            if (sts.cur_tr == TR_APPEAR) begin
              cmd.op = OP_APPEAR;
            end else if (sts.cur_tr == TR_LEFT || sts.cur_tr == TR_RIGHT ||
                         sts.cur_tr == TR_UP || sts.cur_tr == TR_DOWN) begin
              cmd.op = OP_SLIDE;
              phase_nxt = PH_SLIDE;
              state_nxt = S_DIV;
            end else begin
              cmd.op = OP_HOLD;
            end
          end
          PH_SLIDE: begin
            cmd.op = OP_STEP;
            if (sts.step_done) begin
              phase_nxt = PH_ITEM;
            end
          end
          default: begin
            cmd.op = OP_START;
            phase_nxt = PH_ITEM;
          end
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/led_slide_transition_sequencer.sv]
// Top level of the LED slide transition sequencer.
// Depends on lsts_pkg, lsts_ctrl and lsts_dp.
//
// An input transfer with func set writes one playlist entry. An input
// transfer with func clear is an action event and yields one result transfer; the block
// then stalls its input through two table reads, one update and one result load, and on
// the event that starts a slide also while a restoring divider produces the slide
// interval one quotient bit per cycle.
// The result load waits further while the previous result is still stalled at the output.
// A finished result waits in the output register while the next item is taken. The item
// count register may be written whenever no item is in work.
module led_slide_transition_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [2:0]        in_entry_index,
  input  logic [2:0]        in_entry_transition,
  input  logic [15:0]       in_entry_show_ms,
  input  logic [15:0]       in_entry_slide_ms,
  input  logic [3:0]        in_entry_pad,
  input  logic [6:0]        in_entry_columns,
  input  logic [6:0]        in_entry_rows,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_cur_index,
  output logic [2:0]        out_next_index,
  output logic signed [7:0] out_cur_origin_x,
  output logic signed [7:0] out_cur_origin_y,
  output logic signed [7:0] out_next_origin_x,
  output logic signed [7:0] out_next_origin_y,
  output logic [15:0]       out_interval_ms,
  output logic [7:0]        out_visible_mask,
  output logic [2:0]        out_pad_side,
  output logic [3:0]        out_pad_value,
  output logic              out_clear_pads,
  output logic              out_redraw
);
  import lsts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsts_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_entry_index      (in_entry_index),
    .in_entry_transition (in_entry_transition),
    .in_entry_show_ms    (in_entry_show_ms),
    .in_entry_slide_ms   (in_entry_slide_ms),
    .in_entry_pad        (in_entry_pad),
    .in_entry_columns    (in_entry_columns),
    .in_entry_rows       (in_entry_rows),
    .out_cur_index       (out_cur_index),
    .out_next_index      (out_next_index),
    .out_cur_origin_x    (out_cur_origin_x),
    .out_cur_origin_y    (out_cur_origin_y),
    .out_next_origin_x   (out_next_origin_x),
    .out_next_origin_y   (out_next_origin_y),
    .out_interval_ms     (out_interval_ms),
    .out_visible_mask    (out_visible_mask),
    .out_pad_side        (out_pad_side),
    .out_pad_value       (out_pad_value),
    .out_clear_pads      (out_clear_pads),
    .out_redraw          (out_redraw)
  );

endmodule
